// ----- hdl/rxpr_pkg.sv -----
// Package for the receive packet ring: parameter defaults, request and result codes.
// Has no dependencies; used by rx_packet_ring_drop_oldest.
package rxpr_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_PAYLOAD_DEF = 32;

    // Request codes on the input channel.
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_END  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // Result kinds on the output channel.
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

endpackage

// ----- hdl/rx_packet_ring_drop_oldest.sv -----
// Receive packet queue: staging buffer, frame ring with drop-oldest, and read streaming.
// Depends on rxpr_pkg for parameter defaults and request/result codes.
//
// Usage: the input channel (i_valid / o_stall) carries three request types. A frame
// byte goes to the staging buffer; bytes past MAX_PAYLOAD are dropped. A frame end
// updates the counters and puts one status result in the output register at the
// next edge. A good frame of length 1..MAX_PAYLOAD is then copied from staging into
// its ring slot, one byte per cycle through the staging memory's read port, while
// o_stall stays high. When the ring is full the oldest frame is dropped.
// A read request looks up the frame length in the length memory, then streams
// min(length, buf_size) bytes through the frame memory read and the output register,
// one byte per cycle while the receiver does not stall, and keeps o_stall high
// until the read is done. An empty queue or a zero-size buffer gives one empty result.
// The output channel (o_valid / i_stall) is a single output register; while the
// receiver stalls, streaming pauses and the block holds its requests off.
// Reset clears counters, slots and the staging count; the memories are not cleared.
module rx_packet_ring_drop_oldest #(
    parameter int QUEUE_DEPTH = rxpr_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_PAYLOAD = rxpr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_req_type,
    input  logic [7:0]         i_data_byte,
    input  logic [7:0]         i_frame_len,
    input  logic               i_crc_ok,
    input  logic signed [7:0]  i_rssi,
    input  logic [11:0]        i_buf_size,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_out_byte,
    output logic [5:0]         o_read_size,
    output logic               o_last,
    output logic [31:0]        o_end_count,
    output logic [31:0]        o_good_count,
    output logic [31:0]        o_bad_count,
    output logic [7:0]         o_recent_length,
    output logic signed [7:0]  o_recent_rssi
);

    localparam int SW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(MAX_PAYLOAD + 1);
    localparam int SIW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int QD  = QUEUE_DEPTH * MAX_PAYLOAD;
    localparam int AW  = $clog2(QD);
    localparam logic [7:0]    MAX_B    = 8'(MAX_PAYLOAD);
    localparam logic [SW-1:0] LAST_SLOT = SW'(QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COPY,
        S_RLEN,
        S_STREAM
    } t_state;

    t_state r_state;

    // Memories and their read data registers.
    logic [7:0] r_stg_mem [MAX_PAYLOAD];
    logic [7:0] r_q_mem   [QD];
    logic [7:0] r_len_mem [QUEUE_DEPTH];
    logic [7:0] r_stg_rdata;
    logic [7:0] r_q_rdata;
    logic [7:0] r_len_rdata;

    // Control and status registers.
    logic [SW-1:0] r_wslot;
    logic [SW-1:0] r_rslot;
    logic [CW-1:0] r_stg_cnt;
    logic [31:0]   r_end_cnt;
    logic [31:0]   r_good_cnt;
    logic [31:0]   r_bad_cnt;

    // Copy sequencer.
    logic [CW-1:0] r_cp_len;
    logic [CW-1:0] r_cp_issue;
    logic [AW-1:0] r_cp_base;
    logic [AW-1:0] r_cp_waddr;
    logic          r_cp_wvalid;

    // Read sequencer.
    logic [AW-1:0] r_rd_base;
    logic [11:0]   r_bsize;
    logic [7:0]    r_n;
    logic [7:0]    r_issue;
    logic [7:0]    r_sent;
    logic          r_qvalid;

    // Output register.
    logic          r_o_valid;
    logic [1:0]    r_o_kind;
    logic [7:0]    r_o_byte;
    logic [5:0]    r_o_size;
    logic          r_o_last;
    logic [31:0]   r_o_end;
    logic [31:0]   r_o_good;
    logic [31:0]   r_o_bad;
    logic [7:0]    r_o_len;
    logic [7:0]    r_o_rssi;

    // Combinational control.
    logic          out_free;
    logic          accept;
    logic          push;
    logic          stg_full;
    logic [SW-1:0] w_next;
    logic [SW-1:0] r_next;
    logic [7:0]    len_clip;
    logic [7:0]    rd_count;
    logic          stg_we;
    logic          stg_re;
    logic          q_re;
    logic [AW-1:0] q_raddr;
    logic          len_we;
    logic          len_re;

    assign out_free = !r_o_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE) || !out_free;
    assign accept   = i_valid && !o_stall;
    assign stg_full = r_stg_cnt >= CW'(MAX_PAYLOAD);
    assign w_next   = (r_wslot == LAST_SLOT) ? '0 : r_wslot + 1'b1;
    assign r_next   = (r_rslot == LAST_SLOT) ? '0 : r_rslot + 1'b1;
    assign push     = accept && (i_req_type == rxpr_pkg::REQ_END) && i_crc_ok
                      && (i_frame_len != 8'd0) && (i_frame_len <= MAX_B);
    assign len_clip = (r_len_rdata > MAX_B) ? MAX_B : r_len_rdata;
    assign rd_count = ({4'd0, len_clip} <= r_bsize) ? len_clip : r_bsize[7:0];

    assign stg_we = accept && (i_req_type == rxpr_pkg::REQ_BYTE) && !stg_full;
    assign stg_re = (r_state == S_COPY) && (r_cp_issue < r_cp_len);
    assign len_we = push;
    assign len_re = accept && (i_req_type == rxpr_pkg::REQ_READ) && (r_rslot != r_wslot);
    assign q_re   = ((r_state == S_RLEN) && (rd_count != 8'd0))
                    || ((r_state == S_STREAM) && r_qvalid && out_free && (r_issue < r_n));
    assign q_raddr = (r_state == S_RLEN) ? r_rd_base : r_rd_base + AW'(r_issue);

    always_ff @(posedge i_clk) begin
        if (stg_we) begin
            r_stg_mem[r_stg_cnt[SIW-1:0]] <= i_data_byte;
        end
        if (stg_re) begin
            r_stg_rdata <= r_stg_mem[r_cp_issue[SIW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cp_wvalid) begin
            r_q_mem[r_cp_waddr] <= r_stg_rdata;
        end
        if (q_re) begin
            r_q_rdata <= r_q_mem[q_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_len_mem[r_wslot] <= i_frame_len;
        end
        if (len_re) begin
            r_len_rdata <= r_len_mem[r_rslot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wslot     <= '0;
            r_rslot     <= '0;
            r_stg_cnt   <= '0;
            r_end_cnt   <= '0;
            r_good_cnt  <= '0;
            r_bad_cnt   <= '0;
            r_cp_wvalid <= 1'b0;
            r_qvalid    <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_req_type)
                            rxpr_pkg::REQ_BYTE: begin
                                if (!stg_full) begin
                                    r_stg_cnt <= r_stg_cnt + 1'b1;
                                end
                            end
                            rxpr_pkg::REQ_END: begin
                                r_end_cnt   <= r_end_cnt + 32'd1;
                                r_stg_cnt   <= '0;
                                r_o_valid   <= 1'b1;
                                r_o_kind    <= rxpr_pkg::KIND_STATUS;
                                r_o_byte    <= '0;
                                r_o_size    <= '0;
                                r_o_last    <= 1'b1;
                                r_o_end     <= r_end_cnt + 32'd1;
                                r_o_len     <= i_frame_len;
                                r_o_rssi    <= i_rssi;
                                if (i_crc_ok) begin
                                    r_good_cnt <= r_good_cnt + 32'd1;
                                    r_o_good   <= r_good_cnt + 32'd1;
                                    r_o_bad    <= r_bad_cnt;
                                end else begin
                                    r_bad_cnt  <= r_bad_cnt + 32'd1;
                                    r_o_good   <= r_good_cnt;
                                    r_o_bad    <= r_bad_cnt + 32'd1;
                                end
                                if (push) begin
                                    // Ring full: the oldest frame gives way.
                                    if (w_next == r_rslot) begin
                                        r_rslot <= r_next;
                                    end
                                    r_wslot     <= w_next;
                                    r_cp_len    <= CW'(i_frame_len);
                                    r_cp_issue  <= '0;
                                    r_cp_base   <= AW'(r_wslot) * AW'(MAX_PAYLOAD);
                                    r_cp_wvalid <= 1'b0;
                                    r_state     <= S_COPY;
                                end
                            end
                            rxpr_pkg::REQ_READ: begin
                                if (r_rslot == r_wslot) begin
                                    r_o_valid <= 1'b1;
                                    r_o_kind  <= rxpr_pkg::KIND_EMPTY;
                                    r_o_byte  <= '0;
                                    r_o_size  <= '0;
                                    r_o_last  <= 1'b1;
                                    r_o_end   <= '0;
                                    r_o_good  <= '0;
                                    r_o_bad   <= '0;
                                    r_o_len   <= '0;
                                    r_o_rssi  <= '0;
                                end else begin
                                    r_rslot   <= r_next;
                                    r_rd_base <= AW'(r_rslot) * AW'(MAX_PAYLOAD);
                                    r_bsize   <= i_buf_size;
                                    r_state   <= S_RLEN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_COPY: begin
                    // The write of each byte follows its staging read in the next cycle.
                    if (r_cp_issue < r_cp_len) begin
                        r_cp_issue  <= r_cp_issue + 1'b1;
                        r_cp_waddr  <= r_cp_base + AW'(r_cp_issue);
                        r_cp_wvalid <= 1'b1;
                    end else begin
                        r_cp_wvalid <= 1'b0;
                        if (!r_cp_wvalid) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_RLEN: begin
                    if (rd_count != 8'd0) begin
                        r_n      <= rd_count;
                        r_issue  <= 8'd1;
                        r_sent   <= 8'd0;
                        r_qvalid <= 1'b1;
                        r_state  <= S_STREAM;
                    end else if (out_free) begin
                        // A zero-size buffer discards the popped frame.
                        r_o_valid <= 1'b1;
                        r_o_kind  <= rxpr_pkg::KIND_EMPTY;
                        r_o_byte  <= '0;
                        r_o_size  <= '0;
                        r_o_last  <= 1'b1;
                        r_o_end   <= '0;
                        r_o_good  <= '0;
                        r_o_bad   <= '0;
                        r_o_len   <= '0;
                        r_o_rssi  <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                S_STREAM: begin
                    if (r_qvalid && out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= rxpr_pkg::KIND_DATA;
                        r_o_byte  <= r_q_rdata;
                        r_o_size  <= r_n[5:0];
                        r_o_last  <= (r_sent + 8'd1 == r_n);
                        r_o_end   <= '0;
                        r_o_good  <= '0;
                        r_o_bad   <= '0;
                        r_o_len   <= '0;
                        r_o_rssi  <= '0;
                        r_sent    <= r_sent + 8'd1;
                        if (r_issue < r_n) begin
                            r_issue <= r_issue + 8'd1;
                        end else begin
                            r_qvalid <= 1'b0;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_o_valid;
    assign o_kind          = r_o_kind;
    assign o_out_byte      = r_o_byte;
    assign o_read_size     = r_o_size;
    assign o_last          = r_o_last;
    assign o_end_count     = r_o_end;
    assign o_good_count    = r_o_good;
    assign o_bad_count     = r_o_bad;
    assign o_recent_length = r_o_len;
    assign o_recent_rssi   = r_o_rssi;

    // A push always leaves at least one frame in the ring.
    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (r_wslot != r_rslot))
        else $error("ring empty right after a push");

    a_stage_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stg_cnt <= CW'(MAX_PAYLOAD))
        else $error("staging count beyond maximum payload");

    a_copy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_cp_issue <= r_cp_len))
        else $error("copy sequencer ran past the frame length");

    a_stream_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STREAM) |-> (r_sent < r_n) && (r_issue <= r_n))
        else $error("read stream ran past its byte count");

    // A data transfer marked last ends the stream.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STREAM && r_qvalid && out_free && r_sent + 8'd1 == r_n)
        |=> (r_state == S_IDLE) && r_o_last)
        else $error("stream did not end after its last byte");

endmodule
